[rtl/hnm_pkg.sv]
// Shared types and constants of the heightmap normal map block.
// No dependencies; every other file of the block imports this package.
package hnm_pkg;

  localparam int unsigned DefMaxWidth = 1024;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned WidthRegW = 11;
  localparam int unsigned HeightRegW = 16;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned MagBits = 15;
  localparam int unsigned MetaStages = MagBits + 2;

  localparam logic [WidthRegW-1:0] WidthReset = 11'd1024;
  localparam logic [HeightRegW-1:0] HeightReset = 16'd1024;
  localparam logic [MagBits-1:0] OneQ14 = 15'd16384;
  localparam logic [15:0] VertTermSq = 16'd400;

  localparam logic [CfgIdxW-1:0] RegImageWidth = 8'd0;
  localparam logic [CfgIdxW-1:0] RegImageHeight = 8'd1;

  typedef struct packed {
    logic signed [8:0] gx;
    logic signed [8:0] gz;
    logic              border;
    logic              second;
    logic [9:0]        col;
    logic [15:0]       row;
  } hnm_item_t;

endpackage

[rtl/hnm_fifo.sv]
// Short queue that decouples the line buffer front from the normalizing back.
// Depends on hnm_pkg for the item type and depth.
module hnm_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  hnm_pkg::hnm_item_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output hnm_pkg::hnm_item_t data_o,
  output logic              empty_o
);
  import hnm_pkg::*;

  localparam int unsigned PtrW = $clog2(FifoDepth);

  hnm_item_t        mem_q [FifoDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]    count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == (PtrW+1)'(FifoDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop) count_q <= count_q + 1'b1;
      else if (do_pop && !do_push) count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

[rtl/hnm_front.sv]
// Front part: configuration registers, raster position, line buffer memory
// and gradient forming. Depends on hnm_pkg.
module hnm_front #(
  parameter int unsigned MAX_WIDTH = hnm_pkg::DefMaxWidth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [hnm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [hnm_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   height_sample_i,
  output logic                         push_o,
  output hnm_pkg::hnm_item_t           item_o,
  input  logic                         full_i
);
  import hnm_pkg::*;

  localparam int unsigned XW = $clog2(MAX_WIDTH);
  localparam int unsigned CW = (XW + 1 > WidthRegW) ? XW + 1 : WidthRegW;

  logic [WidthRegW-1:0]  width_q;
  logic [HeightRegW-1:0] height_q;
  logic [XW-1:0]         x_q;
  logic [15:0]           y_q;
  logic [CW-1:0]         w_ext, w_eff;
  logic [15:0]           h_eff;
  logic                  x_last, y_last, cfg_wr, accept, advance;

  logic                  s1_valid_q, s1_produce_q, s1_border_q, s1_second_q;
  logic [XW-1:0]         s1_x_q;
  logic [15:0]           s1_row_q;
  logic [7:0]            s1_sample_q;
  logic [15:0]           rd_cur_q;
  logic [7:0]            rd_next_q, prev_mid_q;
  logic [15:0]           line_mem [MAX_WIDTH];

  assign cfg_ready_o = 1'b1;
  assign cfg_wr = cfg_valid_i && cfg_ready_o;

  assign w_ext = CW'(width_q);
  assign w_eff = (w_ext < CW'(2)) ? CW'(2) :
                 (w_ext > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : w_ext;
  assign h_eff = (height_q < 16'd2) ? 16'd2 : height_q;
  assign x_last = (CW'(x_q) == w_eff - CW'(1));
  assign y_last = (y_q == h_eff - 16'd1);

  assign advance = s1_valid_q && (!s1_produce_q || !full_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign accept = in_valid_i && !in_stall_o;
  assign push_o = advance && s1_produce_q;

  always_comb begin
    item_o.gx = $signed({1'b0, prev_mid_q}) - $signed({1'b0, rd_next_q});
    item_o.gz = $signed({1'b0, rd_cur_q[15:8]}) - $signed({1'b0, s1_sample_q});
    item_o.border = s1_border_q;
    item_o.second = s1_second_q;
    item_o.col = 10'(s1_x_q);
    item_o.row = s1_row_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= WidthReset;
      height_q   <= HeightReset;
      x_q        <= '0;
      y_q        <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (cfg_wr) begin
        if (cfg_index_i == RegImageWidth) begin
          width_q <= cfg_data_i[WidthRegW-1:0];
          x_q     <= '0;
          y_q     <= '0;
        end else if (cfg_index_i == RegImageHeight) begin
          height_q <= cfg_data_i[HeightRegW-1:0];
          x_q      <= '0;
          y_q      <= '0;
        end
      end else if (accept) begin
        if (x_last) begin
          x_q <= '0;
          y_q <= y_last ? 16'd0 : y_q + 16'd1;
        end else begin
          x_q <= x_q + 1'b1;
        end
      end
      if (accept) s1_valid_q <= 1'b1;
      else if (advance) s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_sample_q  <= height_sample_i;
      s1_x_q       <= x_q;
      s1_row_q     <= y_q - 16'd1;
      s1_produce_q <= (y_q != 16'd0);
      s1_border_q  <= (y_q == 16'd1) || (x_q == '0) || x_last;
      s1_second_q  <= y_last;
      rd_cur_q     <= line_mem[x_q];
      rd_next_q    <= line_mem[x_q + 1'b1][7:0];
    end
    if (advance) begin
      line_mem[s1_x_q] <= {rd_cur_q[7:0], s1_sample_q};
      prev_mid_q       <= rd_cur_q[7:0];
    end
  end

endmodule

[rtl/hnm_mag_pipe.sv]
// Pipelined exact unit-length scaling: one result bit per stage, using
// shifts and adds on running products. Depends on hnm_pkg.
module hnm_mag_pipe (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [15:0]                 g_sq_i,
  input  logic [16:0]                 s_i,
  output logic [hnm_pkg::MagBits-1:0] mag_o
);
  import hnm_pkg::*;

  localparam int unsigned AccW = 52;

  logic signed [AccW-1:0] p_q [MagBits];
  logic signed [AccW-1:0] q_q [MagBits];
  logic signed [AccW-1:0] t_q [MagBits];
  logic [16:0]            s_q [MagBits];
  logic [MagBits-1:0]     n_q [MagBits];

  for (genvar k = 0; k < MagBits; k++) begin : g_step
    localparam int unsigned Bit = MagBits - 1 - k;
    logic signed [AccW-1:0] p_in, q_in, t_in, s_ext, cand;
    logic [16:0]            s_in;
    logic [MagBits-1:0]     n_in;
    logic                   take;

    if (k == 0) begin : g_init
      assign s_in = s_i;
      assign p_in = $signed({{(AccW-17){1'b0}}, s_i});
      assign q_in = -$signed({{(AccW-17){1'b0}}, s_i});
      assign t_in = $signed({{(AccW-16){1'b0}}, g_sq_i}) <<< 30;
      assign n_in = '0;
    end else begin : g_chain
      assign s_in = s_q[k-1];
      assign p_in = p_q[k-1];
      assign q_in = q_q[k-1];
      assign t_in = t_q[k-1];
      assign n_in = n_q[k-1];
    end

    assign s_ext = $signed({{(AccW-17){1'b0}}, s_in});
    assign cand = p_in + (q_in <<< (Bit + 2)) + (s_ext <<< (2 * Bit + 2));
    assign take = (cand <= t_in);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        p_q[k] <= take ? cand : p_in;
        q_q[k] <= take ? q_in + (s_ext <<< (Bit + 1)) : q_in;
        t_q[k] <= t_in;
        s_q[k] <= s_in;
        n_q[k] <= take ? (n_in | (MagBits'(1) << Bit)) : n_in;
      end
    end
  end

  assign mag_o = n_q[MagBits-1];

endmodule

[rtl/hnm_back.sv]
// Back part: squares, three scaling pipelines and the result emitter that
// sends one or two results per item. Depends on hnm_pkg and hnm_mag_pipe.
module hnm_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         empty_i,
  input  hnm_pkg::hnm_item_t           item_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [15:0]           normal_x_o,
  output logic [14:0]                  normal_y_o,
  output logic signed [15:0]           normal_z_o,
  output logic [9:0]                   pixel_column_o,
  output logic [15:0]                  pixel_row_o,
  output logic                         run_last_o
);
  import hnm_pkg::*;

  hnm_item_t           meta_q [MetaStages];
  logic [MetaStages-1:0] vld_q;
  logic                phase_q, pipe_en, xfer, done;
  logic [7:0]          ax, az;
  logic [15:0]         ax_sq, az_sq;
  logic [15:0]         gx_sq_q, gz_sq_q;
  logic [16:0]         s_q;
  logic [MagBits-1:0]  mag_x, mag_y, mag_z;
  hnm_item_t           m;

  assign m = meta_q[MetaStages-1];
  assign out_valid_o = vld_q[MetaStages-1];
  assign xfer = out_valid_o && !out_stall_i;
  assign done = xfer && (phase_q || !m.second);
  assign pipe_en = !out_valid_o || done;
  assign pop_o = pipe_en && !empty_i;

  assign ax = 8'(meta_q[0].gx[8] ? -meta_q[0].gx : meta_q[0].gx);
  assign az = 8'(meta_q[0].gz[8] ? -meta_q[0].gz : meta_q[0].gz);
  assign ax_sq = 16'(ax) * 16'(ax);
  assign az_sq = 16'(az) * 16'(az);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      phase_q <= 1'b0;
    end else begin
      if (pipe_en) vld_q <= {vld_q[MetaStages-2:0], !empty_i};
      if (xfer) phase_q <= !done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      meta_q[0] <= item_i;
      for (int i = 1; i < MetaStages; i++) meta_q[i] <= meta_q[i-1];
      gx_sq_q <= ax_sq;
      gz_sq_q <= az_sq;
      s_q     <= 17'(ax_sq) + 17'(az_sq) + 17'(VertTermSq);
    end
  end

  hnm_mag_pipe u_mag_x (
    .clk_i(clk_i), .en_i(pipe_en), .g_sq_i(gx_sq_q), .s_i(s_q), .mag_o(mag_x)
  );
  hnm_mag_pipe u_mag_y (
    .clk_i(clk_i), .en_i(pipe_en), .g_sq_i(VertTermSq), .s_i(s_q), .mag_o(mag_y)
  );
  hnm_mag_pipe u_mag_z (
    .clk_i(clk_i), .en_i(pipe_en), .g_sq_i(gz_sq_q), .s_i(s_q), .mag_o(mag_z)
  );

  always_comb begin
    pixel_column_o = m.col;
    if (phase_q) begin
      normal_x_o  = '0;
      normal_y_o  = OneQ14;
      normal_z_o  = '0;
      pixel_row_o = m.row + 16'd1;
      run_last_o  = 1'b1;
    end else begin
      pixel_row_o = m.row;
      run_last_o  = !m.second;
      if (m.border) begin
        normal_x_o = '0;
        normal_y_o = OneQ14;
        normal_z_o = '0;
      end else begin
        normal_x_o = m.gx[8] ? -$signed({1'b0, mag_x}) : $signed({1'b0, mag_x});
        normal_y_o = mag_y;
        normal_z_o = m.gz[8] ? -$signed({1'b0, mag_z}) : $signed({1'b0, mag_z});
      end
    end
  end

endmodule

[rtl/heightmap_normal_map_top.sv]
// One sample per clock is taken while no stall is pending; a sample of the
// last row sends two results and holds the back part until both have left.
// On its way to the output a result passes the line buffer read, a short
// queue, squaring, and fifteen scaling stages that settle one result bit
// each. Frame size comes from the two registers.
// Top level; depends on hnm_pkg, hnm_front, hnm_fifo and hnm_back.
module heightmap_normal_map_top #(
  parameter int unsigned MAX_WIDTH = hnm_pkg::DefMaxWidth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [hnm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [hnm_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   height_sample_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [15:0]           normal_x_o,
  output logic [14:0]                  normal_y_o,
  output logic signed [15:0]           normal_z_o,
  output logic [9:0]                   pixel_column_o,
  output logic [15:0]                  pixel_row_o,
  output logic                         run_last_o
);
  import hnm_pkg::*;

  hnm_item_t push_item, pop_item;
  logic      push, full, pop, empty;

  hnm_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .height_sample_i(height_sample_i),
    .push_o(push), .item_o(push_item), .full_i(full)
  );

  hnm_fifo u_fifo (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .push_i(push), .data_i(push_item), .full_o(full),
    .pop_i(pop), .data_o(pop_item), .empty_o(empty)
  );

  hnm_back u_back (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .empty_i(empty), .item_i(pop_item), .pop_o(pop),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .normal_x_o(normal_x_o), .normal_y_o(normal_y_o), .normal_z_o(normal_z_o),
    .pixel_column_o(pixel_column_o), .pixel_row_o(pixel_row_o),
    .run_last_o(run_last_o)
  );

endmodule

[test/heightmap_normal_map_top_tb.sv]
// Self-checking testbench for heightmap_normal_map_top: streams height frames,
// predicts every surface normal internally and compares each output transfer.
// Depends on hnm_pkg and the heightmap_normal_map_top RTL.
`timescale 1ns / 100ps

module heightmap_normal_map_top_tb;
  import hnm_pkg::*;

  localparam int unsigned LineLen = 1024;
  localparam int unsigned DrainWait = 40;
  localparam int unsigned StuckLimit = 20000;

  typedef struct packed {
    logic signed [15:0] nx;
    logic [14:0]        ny;
    logic signed [15:0] nz;
    logic [9:0]         col;
    logic [15:0]        row;
    logic               last;
  } normal_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [7:0] height_sample_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [15:0] normal_x_o;
  logic [14:0] normal_y_o;
  logic signed [15:0] normal_z_o;
  logic [9:0] pixel_column_o;
  logic [15:0] pixel_row_o;
  logic run_last_o;

  normal_t pending_normals[$];
  logic [7:0] upper_row[LineLen];
  logic [7:0] middle_row[LineLen];
  int unsigned cur_col, cur_row;
  logic [WidthRegW-1:0] width_reg;
  logic [HeightRegW-1:0] height_reg;

  int unsigned idle_pct, stall_pct, stuck_cycles;
  int unsigned sample_count, normal_count, error_count;
  bit hold_output;

  always #6 clk_i = ~clk_i;

  heightmap_normal_map_top dut (.*);

  function automatic logic [14:0] unit_mag(int unsigned g, int unsigned s);
    longint unsigned target, d;
    int unsigned lo, hi, mid;
    target = (longint'(g) * g) << 30;
    lo = 0;
    hi = 16384;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      d = 2 * longint'(mid) - 1;
      if (d * d * s <= target) lo = mid;
      else hi = mid - 1;
    end
    return lo[14:0];
  endfunction

  function automatic logic [15:0] signed_unit(int g, int unsigned s);
    logic [15:0] m;
    m = {1'b0, unit_mag(g < 0 ? -g : g, s)};
    return g < 0 ? -m : m;
  endfunction

  function automatic void predict_normals(logic [7:0] smp);
    int unsigned w, h, x, y, s;
    int gx, gz;
    normal_t n;
    w = width_reg;
    h = height_reg;
    if (w < 2) w = 2;
    if (w > LineLen) w = LineLen;
    if (h < 2) h = 2;
    if (cur_col >= w) cur_col = 0;
    if (cur_row >= h) cur_row = 0;
    x = cur_col;
    y = cur_row;
    if (y >= 1) begin
      n.col = x[9:0];
      n.row = y[15:0] - 16'd1;
      n.last = (y != h - 1);
      if (y == 1 || x == 0 || x == w - 1) begin
        n.nx = '0;
        n.ny = OneQ14;
        n.nz = '0;
      end else begin
        gx = int'(upper_row[x - 1]) - int'(middle_row[x + 1]);
        gz = int'(upper_row[x]) - int'(smp);
        s = gx * gx + gz * gz + 400;
        n.nx = signed_unit(gx, s);
        n.ny = unit_mag(20, s);
        n.nz = signed_unit(gz, s);
      end
      pending_normals.push_back(n);
      if (y == h - 1) begin
        n.nx = '0;
        n.ny = OneQ14;
        n.nz = '0;
        n.row = y[15:0];
        n.last = 1'b1;
        pending_normals.push_back(n);
      end
    end
    upper_row[x] = middle_row[x];
    middle_row[x] = smp;
    cur_col = x + 1;
    if (cur_col >= w) begin
      cur_col = 0;
      cur_row = y + 1;
      if (cur_row >= h) cur_row = 0;
    end
  endfunction

  task automatic send_sample(logic [7:0] smp);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    height_sample_i = smp;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_normals(smp);
    sample_count++;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (pending_normals.size() != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    wait_idle();
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == RegImageWidth) width_reg = data[WidthRegW-1:0];
    if (idx == RegImageHeight) height_reg = data;
    if (idx == RegImageWidth || idx == RegImageHeight) begin
      cur_col = 0;
      cur_row = 0;
    end
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic send_terrain(int unsigned count, bit smooth);
    int v;
    v = $urandom_range(255);
    repeat (count) begin
      if (smooth) begin
        v = v + int'($urandom_range(24)) - 12;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
      end else begin
        v = $urandom_range(255);
      end
      send_sample(v[7:0]);
    end
  endtask

  task automatic test_directed();
    logic [7:0] extremes[12] = '{0, 255, 0, 255, 255, 0, 255, 0, 0, 255, 128, 1};
    write_reg(RegImageWidth, 16'd4);
    write_reg(RegImageHeight, 16'd3);
    foreach (extremes[i]) send_sample(extremes[i]);
    write_reg(RegImageWidth, 16'd2);
    write_reg(RegImageHeight, 16'd2);
    repeat (4) send_sample(8'hff);
    write_reg(8'd2, 16'hffff);
    write_reg(8'hff, 16'h0000);
    repeat (4) send_sample(8'h00);
    write_reg(RegImageWidth, 16'd0);
    write_reg(RegImageHeight, 16'd1);
    repeat (5) send_sample(8'($urandom_range(255)));
  endtask

  task automatic test_random_frames();
    int unsigned modes[4][2] = '{'{0, 0}, '{86, 0}, '{0, 86}, '{16, 16}};
    foreach (modes[m]) begin
      idle_pct = modes[m][0];
      stall_pct = modes[m][1];
      repeat (2) begin
        write_reg(RegImageWidth, 16'($urandom_range(3, 8)));
        write_reg(RegImageHeight, 16'($urandom_range(2, 5)));
        send_terrain($urandom_range(10, 30), $urandom_range(3) != 0);
      end
    end
    idle_pct = 0;
    stall_pct = 16;
    write_reg(RegImageWidth, 16'h07ff);
    write_reg(RegImageHeight, 16'hffff);
    send_terrain(1030, 1'b1);
    write_reg(RegImageWidth, 16'd5);
    send_terrain(24, 1'b0);
    write_reg(RegImageHeight, 16'd2);
    send_terrain(12, 1'b0);
  endtask

  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    write_reg(RegImageWidth, 16'd6);
    write_reg(RegImageHeight, 16'd4);
    fork
      begin
        hold_output = 1'b1;
        repeat (300) @(negedge clk_i);
        hold_output = 1'b0;
      end
      begin
        send_terrain(48, 1'b0);
        in_valid_i = 1'b0;
      end
    join
  endtask

  always @(negedge clk_i) begin
    out_stall_i = hold_output || ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    normal_t n;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      normal_count++;
      if (pending_normals.size() == 0) begin
        $error("unexpected normal at column %0d row %0d", pixel_column_o, pixel_row_o);
        error_count++;
      end else begin
        n = pending_normals.pop_front();
        if (normal_x_o !== n.nx) begin
          $error("normal_x expected %0d got %0d", n.nx, normal_x_o);
          error_count++;
        end
        if (normal_y_o !== n.ny) begin
          $error("normal_y expected %0d got %0d", n.ny, normal_y_o);
          error_count++;
        end
        if (normal_z_o !== n.nz) begin
          $error("normal_z expected %0d got %0d", n.nz, normal_z_o);
          error_count++;
        end
        if (pixel_column_o !== n.col) begin
          $error("pixel_column expected %0d got %0d", n.col, pixel_column_o);
          error_count++;
        end
        if (pixel_row_o !== n.row) begin
          $error("pixel_row expected %0d got %0d", n.row, pixel_row_o);
          error_count++;
        end
        if (run_last_o !== n.last) begin
          $error("run_last expected %0d got %0d", n.last, run_last_o);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= StuckLimit) begin
      $display("heightmap_normal_map_top: mismatch");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    stuck_cycles = 0;
    hold_output = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    cur_col = 0;
    cur_row = 0;
    width_reg = WidthReset;
    height_reg = HeightReset;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random_frames();
    test_backpressure();
    wait_idle();
    $display("Sent %0d height samples and checked %0d normals over frames from 2 to 1024",
             sample_count, normal_count);
    $display("pixels wide, with idle, stall and long hold-off phases.");
    if (error_count == 0) begin
      $display("heightmap_normal_map_top: match");
    end else begin
      $display("heightmap_normal_map_top: mismatch");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/hnm_pkg.sv
rtl/hnm_fifo.sv
rtl/hnm_front.sv
rtl/hnm_mag_pipe.sv
rtl/hnm_back.sv
rtl/heightmap_normal_map_top.sv
test/heightmap_normal_map_top_tb.sv
